[rtl/core/ptsf_pkg.sv]
package ptsf_pkg;

  // Angles are binary angles: 2^ANGLE_BITS units per turn.
  localparam int unsigned ANGLE_BITS  = 16;
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned VEL_W       = 32;
  // Signed product of a velocity-wide operand and an unsigned time or speed.
  localparam int unsigned PROD_W      = VEL_W + TIME_W + 1;
  // Wide enough for velocity minus both spring terms without overflow.
  localparam int unsigned SUM_W       = 48;
  localparam int unsigned DIV_W       = 52;
  localparam int unsigned PTSF_DIV_STEP_BITS = 4;

  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_TDATA_W  = 5 * 16;
  localparam int unsigned OUT_TDATA_W = 2 * 16;

  localparam logic [TIME_W-1:0] T_FLOOR = 16'd66;

  localparam logic [15:0]                  ROT_SPEED_RST  = 16'd256;
  localparam logic [TIME_W-1:0]            TIME_CONST_RST = 16'd6554;
  localparam logic signed [ANGLE_BITS-1:0] PITCH_MIN_RST  = -16'sd16384;
  localparam logic signed [ANGLE_BITS-1:0] PITCH_MAX_RST  = 16'sd16384;

  localparam logic signed [SUM_W-1:0] VEL_MAX =
    {{(SUM_W-VEL_W+1){1'b0}}, {(VEL_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] VEL_MIN =
    {{(SUM_W-VEL_W+1){1'b1}}, {(VEL_W-1){1'b0}}};

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ROT_SPEED  = 2'd0,
    CFG_TIME_CONST = 2'd1,
    CFG_PITCH_MIN  = 2'd2,
    CFG_PITCH_MAX  = 2'd3
  } ptsf_cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TGT_X,
    ST_TGT_Y,
    ST_TGT_P,
    ST_ERR,
    ST_S1_GO,
    ST_S1_WAIT,
    ST_K_WAIT,
    ST_C_GO,
    ST_C_WAIT,
    ST_MOVE,
    ST_NEXT
  } ptsf_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } ptsf_div_stat_t;

endpackage

[rtl/core/pan_tilt_spring_follower_core.sv]
// Channel      Direction  Handshake                      Payload
// s_axis       in         s_axis_tvalid / s_axis_tready  mouse deltas, step time, angles
// m_axis       out        m_axis_tvalid / m_axis_tready  next yaw and pitch
// cfg          in         cfg_we_i (no ready)            register index and value
//
// An accepted request has its result loaded into the output register as the sequencer returns
// to idle, and only then is the input ready again, so one request is in flight at a time. The
// target moves first, then each axis runs three 52-bit divisions through the shared divider
// (four quotient bits per cycle) and three multiplies on the shared 32x17 multiplier. A full
// output register holds the sequencer in its last step. Reset restores the register defaults
// and clears targets and velocities.
module pan_tilt_spring_follower_core import ptsf_pkg::*; #(
  parameter int unsigned DivStepBits = PTSF_DIV_STEP_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // mouse_x [15:0], mouse_y [31:16], delta_time [47:32],
  // current_yaw [63:48], current_pitch [79:64]
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // next_yaw [15:0], next_pitch [31:16]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [ANGLE_BITS+1:0] wide_angle_t;

  function automatic angle_t clamp_pitch(input wide_angle_t x, input angle_t lo,
                                         input angle_t hi);
    wide_angle_t lo_x, hi_x;
    lo_x = {{2{lo[ANGLE_BITS-1]}}, lo};
    hi_x = {{2{hi[ANGLE_BITS-1]}}, hi};
    if (x < lo_x) begin
      return lo;
    end else if (x < hi_x) begin
      return x[ANGLE_BITS-1:0];
    end else begin
      return hi;
    end
  endfunction

  ptsf_state_e state_q, state_d;

  logic                     axis_q, axis_d;
  logic                     seeded_q, seeded_d;
  angle_t                   tgt_y_q, tgt_y_d, tgt_p_q, tgt_p_d;
  logic signed [VEL_W-1:0]  vel_y_q, vel_y_d, vel_p_q, vel_p_d;
  logic [15:0]              rot_q;
  logic [TIME_W-1:0]        tc_q;
  angle_t                   pmin_q, pmax_q;

  logic                     in_ld;
  logic signed [15:0]       mx_q, my_q;
  logic [TIME_W-1:0]        dt_q;
  angle_t                   cy_q, cp_q;

  logic                     prod_en;
  logic signed [VEL_W-1:0]  mul_a;
  logic [TIME_W-1:0]        mul_b;
  logic signed [TIME_W:0]   mul_bx;
  logic signed [PROD_W-1:0] prod_full, prod_q;
  logic [PROD_W-1:0]        prod_mag;

  logic                     neg_q, neg_d;
  logic signed [SUM_W-1:0]  kterm_q, kterm_d;
  angle_t                   ny_q, ny_d;

  logic                     out_valid_q, out_valid_d;
  angle_t                   out_y_q, out_y_d, out_p_q, out_p_d;
  logic                     out_free;

  logic                     div_start;
  logic [DIV_W-1:0]         div_dividend;
  logic [TIME_W-1:0]        t_eff;
  ptsf_div_stat_t           div_stat;
  logic [DIV_W-1:0]         div_quo;

  angle_t                   cur_axis, tgt_axis, err, nxt, base_y, base_p;
  logic signed [VEL_W-1:0]  vel_axis;
  logic signed [SUM_W-1:0]  quo_s, vel_sum, vel_sat;
  wide_angle_t              sum_p;

  assign t_eff = (tc_q < T_FLOOR) ? T_FLOOR : tc_q;

  ptsf_div #(
    .DivW     (DIV_W),
    .DenW     (TIME_W),
    .StepBits (DivStepBits)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (t_eff),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  assign cur_axis = axis_q ? cp_q : cy_q;
  assign tgt_axis = axis_q ? tgt_p_q : tgt_y_q;
  assign vel_axis = axis_q ? vel_p_q : vel_y_q;
  assign err      = cur_axis - tgt_axis;
  // The low angle bits of the velocity step, floor-shifted by 24.
  assign nxt      = cur_axis + prod_q[ANGLE_BITS+23:24];

  assign base_y = seeded_q ? tgt_y_q : cy_q;
  assign base_p = seeded_q ? tgt_p_q : cp_q;
  assign sum_p  = {{2{base_p[ANGLE_BITS-1]}}, base_p}
                + {prod_q[32], prod_q[32:16]};

  assign mul_bx    = {1'b0, mul_b};
  assign prod_full = mul_a * mul_bx;
  assign prod_mag  = prod_q[PROD_W-1] ? (~prod_q + 1'b1) : prod_q;

  assign quo_s   = neg_q ? (~div_quo[SUM_W-1:0] + 1'b1) : div_quo[SUM_W-1:0];
  assign vel_sum = {{(SUM_W-VEL_W){vel_axis[VEL_W-1]}}, vel_axis} - kterm_q - quo_s;
  assign vel_sat = (vel_sum > VEL_MAX) ? VEL_MAX :
                   (vel_sum < VEL_MIN) ? VEL_MIN : vel_sum;

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d      = state_q;
    axis_d       = axis_q;
    seeded_d     = seeded_q;
    tgt_y_d      = tgt_y_q;
    tgt_p_d      = tgt_p_q;
    vel_y_d      = vel_y_q;
    vel_p_d      = vel_p_q;
    neg_d        = neg_q;
    kterm_d      = kterm_q;
    ny_d         = ny_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_y_d      = out_y_q;
    out_p_d      = out_p_q;
    in_ld        = 1'b0;
    prod_en      = 1'b0;
    mul_a        = vel_axis;
    mul_b        = dt_q;
    div_start    = 1'b0;
    div_dividend = {prod_mag[43:0], 8'b0};
    s_axis_tready = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          in_ld   = 1'b1;
          state_d = ST_TGT_X;
        end
      end
      ST_TGT_X: begin
        mul_a   = VEL_W'(mx_q);
        mul_b   = rot_q;
        prod_en = 1'b1;
        state_d = ST_TGT_Y;
      end
      ST_TGT_Y: begin
        tgt_y_d = base_y + prod_q[31:16];
        mul_a   = VEL_W'(my_q);
        mul_b   = rot_q;
        prod_en = 1'b1;
        state_d = ST_TGT_P;
      end
      ST_TGT_P: begin
        tgt_p_d  = clamp_pitch(sum_p, pmin_q, pmax_q);
        seeded_d = 1'b1;
        axis_d   = 1'b0;
        state_d  = ST_ERR;
      end
      ST_ERR: begin
        mul_a   = VEL_W'(err);
        prod_en = 1'b1;
        state_d = ST_S1_GO;
      end
      ST_S1_GO: begin
        // Spring term numerator: err * dt * 256.
        neg_d        = prod_q[PROD_W-1];
        div_dividend = {prod_mag[43:0], 8'b0};
        div_start    = 1'b1;
        state_d      = ST_S1_WAIT;
      end
      ST_S1_WAIT: begin
        // The truncated first quotient is divided again after scaling by
        // 2^16; its sign carries through unchanged.
        if (div_stat.done) begin
          div_dividend = {div_quo[35:0], 16'b0};
          div_start    = 1'b1;
          state_d      = ST_K_WAIT;
        end
      end
      ST_K_WAIT: begin
        if (div_stat.done) begin
          kterm_d = quo_s;
          prod_en = 1'b1;
          state_d = ST_C_GO;
        end
      end
      ST_C_GO: begin
        // Damping numerator: vel * 2 * dt.
        neg_d        = prod_q[PROD_W-1];
        div_dividend = {2'b0, prod_mag, 1'b0};
        div_start    = 1'b1;
        state_d      = ST_C_WAIT;
      end
      ST_C_WAIT: begin
        if (div_stat.done) begin
          if (axis_q) begin
            vel_p_d = vel_sat[VEL_W-1:0];
          end else begin
            vel_y_d = vel_sat[VEL_W-1:0];
          end
          state_d = ST_MOVE;
        end
      end
      ST_MOVE: begin
        prod_en = 1'b1;
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (!axis_q) begin
          ny_d    = nxt;
          axis_d  = 1'b1;
          state_d = ST_ERR;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_y_d     = ny_q;
          out_p_d     = clamp_pitch({{2{nxt[ANGLE_BITS-1]}}, nxt}, pmin_q, pmax_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      seeded_q    <= 1'b0;
      tgt_y_q     <= '0;
      tgt_p_q     <= '0;
      vel_y_q     <= '0;
      vel_p_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      seeded_q    <= seeded_d;
      tgt_y_q     <= tgt_y_d;
      tgt_p_q     <= tgt_p_d;
      vel_y_q     <= vel_y_d;
      vel_p_q     <= vel_p_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q  <= ROT_SPEED_RST;
      tc_q   <= TIME_CONST_RST;
      pmin_q <= PITCH_MIN_RST;
      pmax_q <= PITCH_MAX_RST;
    end else if (cfg_we_i) begin
      case (ptsf_cfg_reg_e'(cfg_addr_i))
        CFG_ROT_SPEED:  rot_q  <= cfg_wdata_i;
        CFG_TIME_CONST: tc_q   <= cfg_wdata_i;
        CFG_PITCH_MIN:  pmin_q <= cfg_wdata_i;
        CFG_PITCH_MAX:  pmax_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ld) begin
      mx_q <= s_axis_tdata[15:0];
      my_q <= s_axis_tdata[31:16];
      dt_q <= s_axis_tdata[47:32];
      cy_q <= s_axis_tdata[63:48];
      cp_q <= s_axis_tdata[79:64];
    end
    if (prod_en) begin
      prod_q <= prod_full;
    end
    neg_q   <= neg_d;
    kterm_q <= kterm_d;
    ny_q    <= ny_d;
    out_y_q <= out_y_d;
    out_p_q <= out_p_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_p_q, out_y_q};

  // The sequencer only starts the divider once the previous quotient is out.
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // The spring never runs on a target that was not seeded.
  a_seeded_before_spring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ERR) |-> seeded_q)
    else $error("spring step with unseeded target");

  // A result appears only from the final pitch step.
  a_result_from_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_NEXT && axis_q))
    else $error("result loaded outside the final step");

  // No request is taken while a division is still running.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> !div_stat.busy)
    else $error("request accepted during a division");

endmodule

[rtl/core/ptsf_div.sv]
module ptsf_div import ptsf_pkg::*; #(
  parameter int unsigned DivW     = DIV_W,
  parameter int unsigned DenW     = TIME_W,
  parameter int unsigned StepBits = PTSF_DIV_STEP_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DivW-1:0]     dividend_i,
  input  logic [DenW-1:0]     divisor_i,
  output ptsf_div_stat_t      stat_o,
  output logic [DivW-1:0]     quotient_o
);

  localparam int unsigned Steps = DivW / StepBits;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW:0]   rem_q, rem_n;
  logic [DivW-1:0] quo_q, quo_n;
  logic [DenW-1:0] den_q;

  // Restoring division, StepBits quotient bits per cycle. The dividend is
  // shifted out of the top of quo_q while quotient bits enter at the bottom.
  always_comb begin
    logic [DenW:0]   r_v;
    logic [DivW-1:0] q_v;
    r_v = rem_q;
    q_v = quo_q;
    for (int i = 0; i < StepBits; i++) begin
      r_v = {r_v[DenW-1:0], q_v[DivW-1]};
      q_v = {q_v[DivW-2:0], 1'b0};
      if (r_v >= {1'b0, den_q}) begin
        r_v    = r_v - {1'b0, den_q};
        q_v[0] = 1'b1;
      end
    end
    rem_n = r_v;
    quo_n = q_v;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(Steps);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

[bench/pan_tilt_spring_follower_core_test.sv]
module pan_tilt_spring_follower_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ptsf_pkg::*;

  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned END_PAUSE       = 120;
  localparam int unsigned QUIET_LIMIT     = 3000;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 185;
  localparam int unsigned SHOWN_FAILURES  = 10;

  localparam longint S1_CAP = 64'sh0000_4000_0000_0000;
  localparam longint VEL_HI = 64'sd2147483647;
  localparam longint VEL_LO = -64'sd2147483648;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // First member in the top bits, so mouse_x lands in the lowest bits of tdata.
  typedef struct packed {
    logic signed [15:0] cur_pitch;
    logic signed [15:0] cur_yaw;
    logic        [15:0] dtime;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_x;
  } angle_req_t;

  typedef struct packed {
    logic signed [15:0] next_pitch;
    logic signed [15:0] next_yaw;
  } angle_res_t;

  typedef struct packed {
    logic          is_cfg;
    ptsf_cfg_reg_e reg_sel;
    logic [15:0]   value;
    angle_req_t    req;
    logic          typed;
    angle_res_t    res;
  } dir_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i   = '0;

  pan_tilt_spring_follower_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Register copies and follower state, as they stand after reset.
  logic        [15:0] rot_speed  = ROT_SPEED_RST;
  logic        [15:0] time_const = TIME_CONST_RST;
  logic signed [15:0] pitch_lo   = PITCH_MIN_RST;
  logic signed [15:0] pitch_hi   = PITCH_MAX_RST;
  longint             tgt_yaw    = 0;
  longint             tgt_pitch  = 0;
  longint             yaw_vel    = 0;
  longint             pitch_vel  = 0;
  bit                 seeded     = 1'b0;

  angle_res_t  pending_angles[$];
  angle_res_t  last_angles = '0;
  dir_row_t    dir_rows[$];
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;
  int unsigned mismatches  = 0;
  int unsigned quiet_cycles = 0;

  function automatic longint wrap16(input longint v);
    logic signed [15:0] w;
    w = v[15:0];
    return longint'(w);
  endfunction

  // Crossed limits fall out of the order of the tests: below the minimum wins.
  function automatic longint clamp_pitch(input longint x);
    if (x < longint'(pitch_lo)) return longint'(pitch_lo);
    if (x < longint'(pitch_hi)) return x;
    return longint'(pitch_hi);
  endfunction

  function automatic longint spring_velocity(input longint cur, input longint tgt,
                                             input longint vel, input longint dt,
                                             input longint tc);
    longint err, s1, kterm, cterm, v;
    err = wrap16(cur - tgt);
    s1 = (err * dt * 256) / tc;
    if (s1 > S1_CAP) s1 = S1_CAP;
    if (s1 < -S1_CAP) s1 = -S1_CAP;
    kterm = (s1 * 65536) / tc;
    cterm = (vel * 2 * dt) / tc;
    v = vel - kterm - cterm;
    if (v > VEL_HI) v = VEL_HI;
    if (v < VEL_LO) v = VEL_LO;
    return v;
  endfunction

  function automatic angle_res_t predict_follow(input angle_req_t req);
    angle_res_t res;
    longint mx, my, dt, cy, cp, spd, tc, ny, np;
    mx  = longint'(req.mouse_x);
    my  = longint'(req.mouse_y);
    dt  = longint'(req.dtime);
    cy  = longint'(req.cur_yaw);
    cp  = longint'(req.cur_pitch);
    spd = longint'(rot_speed);
    tc  = (time_const < T_FLOOR) ? longint'(T_FLOOR) : longint'(time_const);
    if (!seeded) begin
      tgt_yaw   = cy;
      tgt_pitch = cp;
      seeded    = 1'b1;
    end
    tgt_yaw   = wrap16(tgt_yaw + ((mx * spd) >>> 16));
    tgt_pitch = wrap16(clamp_pitch(tgt_pitch + ((my * spd) >>> 16)));
    yaw_vel   = spring_velocity(cy, tgt_yaw, yaw_vel, dt, tc);
    pitch_vel = spring_velocity(cp, tgt_pitch, pitch_vel, dt, tc);
    ny = wrap16(cy + ((yaw_vel * dt) >>> 24));
    np = clamp_pitch(wrap16(cp + ((pitch_vel * dt) >>> 24)));
    res.next_yaw   = ny[15:0];
    res.next_pitch = np[15:0];
    return res;
  endfunction

  function automatic dir_row_t item_row(input bit typed, input int mx, input int my,
                                        input int dt, input int cy, input int cp,
                                        input int ey = 0, input int ep = 0);
    dir_row_t row;
    row = '0;
    row.req.mouse_x   = mx[15:0];
    row.req.mouse_y   = my[15:0];
    row.req.dtime     = dt[15:0];
    row.req.cur_yaw   = cy[15:0];
    row.req.cur_pitch = cp[15:0];
    row.typed          = typed;
    row.res.next_yaw   = ey[15:0];
    row.res.next_pitch = ep[15:0];
    return row;
  endfunction

  function automatic dir_row_t reg_row(input ptsf_cfg_reg_e sel, input int value);
    dir_row_t row;
    row = '0;
    row.is_cfg  = 1'b1;
    row.reg_sel = sel;
    row.value   = value[15:0];
    return row;
  endfunction

  task automatic send_request(input angle_req_t req, input bit typed,
                              input angle_res_t typed_res);
    angle_res_t model;
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    model = predict_follow(req);
    pending_angles.push_back(typed ? typed_res : model);
    last_angles = model;
  endtask

  // Registers only change once every request has been answered.
  task automatic cfg_write(input ptsf_cfg_reg_e sel, input logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= sel;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (sel)
      CFG_ROT_SPEED:  rot_speed  = value;
      CFG_TIME_CONST: time_const = value;
      CFG_PITCH_MIN:  pitch_lo   = value;
      CFG_PITCH_MAX:  pitch_hi   = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin : monitor
    angle_res_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_angles.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_FAILURES)
            $display("result with none expected: yaw %0d pitch %0d",
                     got.next_yaw, got.next_pitch);
        end else begin
          want = pending_angles.pop_front();
          if (got.next_yaw !== want.next_yaw || got.next_pitch !== want.next_pitch) begin
            mismatches++;
            if (mismatches <= SHOWN_FAILURES)
              $display("angle mismatch: expected yaw %0d pitch %0d, got yaw %0d pitch %0d",
                       want.next_yaw, want.next_pitch, got.next_yaw, got.next_pitch);
          end
        end
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("pan_tilt_spring_follower_core_test NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    angle_req_t         req;
    logic        [31:0] r0, r1, r2;
    logic        [15:0] rs, tc;
    logic signed [15:0] pl, ph, swap;
    int                 span;
    int unsigned        pick;
    idle_mode_e         mode;

    // Seeding, zero step time and pitch clamping give results read off directly.
    dir_rows.push_back(item_row(1'b1, 0, 0, 0, 1234, 500, 1234, 500));
    dir_rows.push_back(item_row(1'b1, 1000, -1000, 0, 10, 20, 10, 20));
    dir_rows.push_back(item_row(1'b1, 0, 0, 0, -32768, 32767, -32768, 16384));
    dir_rows.push_back(item_row(1'b1, 0, 0, 0, 32767, -32768, 32767, -16384));
    dir_rows.push_back(item_row(1'b0, 32767, 32767, 1092, 0, 0));
    dir_rows.push_back(item_row(1'b0, -32768, -32768, 65535, 100, -100));
    dir_rows.push_back(item_row(1'b0, 0, 0, 65535, -32768, 32767));
    dir_rows.push_back(item_row(1'b0, 256, -256, 1, 5, -5));
    dir_rows.push_back(reg_row(CFG_TIME_CONST, 0));
    dir_rows.push_back(item_row(1'b0, 512, 512, 1092, 300, 300));
    dir_rows.push_back(item_row(1'b0, 0, 0, 65535, 32767, 16384));
    dir_rows.push_back(reg_row(CFG_TIME_CONST, 65));
    dir_rows.push_back(item_row(1'b0, -700, 900, 2000, -1000, 1000));
    dir_rows.push_back(reg_row(CFG_TIME_CONST, 65535));
    dir_rows.push_back(item_row(1'b0, 32767, -32768, 65535, 0, 0));
    dir_rows.push_back(reg_row(CFG_ROT_SPEED, 0));
    dir_rows.push_back(item_row(1'b0, 32767, 32767, 1092, 200, -200));
    dir_rows.push_back(reg_row(CFG_ROT_SPEED, 65535));
    dir_rows.push_back(item_row(1'b0, -32768, 32767, 1092, 200, -200));
    dir_rows.push_back(reg_row(CFG_PITCH_MIN, 1000));
    dir_rows.push_back(reg_row(CFG_PITCH_MAX, -1000));
    dir_rows.push_back(item_row(1'b1, 0, 0, 0, 77, 500, 77, 1000));
    dir_rows.push_back(item_row(1'b1, 0, 0, 0, -5, 2000, -5, -1000));
    dir_rows.push_back(reg_row(CFG_PITCH_MIN, -32768));
    dir_rows.push_back(reg_row(CFG_PITCH_MAX, 32767));
    dir_rows.push_back(item_row(1'b1, 0, 0, 0, 32767, -32768, 32767, -32768));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        cfg_write(dir_rows[i].reg_sel, dir_rows[i].value);
      else
        send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          rs = ROT_SPEED_RST; tc = TIME_CONST_RST; pl = PITCH_MIN_RST; ph = PITCH_MAX_RST;
        end
        1: begin
          rs = 16'hFFFF; tc = 16'hFFFF; pl = -16'sd32768; ph = 16'sd32767;
        end
        2: begin
          rs = 16'd0; tc = 16'd0; pl = -16'sd32768; ph = 16'sd32767;
        end
        3: begin
          rs = 16'd1000; tc = T_FLOOR; pl = 16'sd8000; ph = -16'sd8000;
        end
        default: begin
          r0 = $urandom();
          r1 = $urandom();
          rs = r0[15:0];
          tc = r0[31:16];
          pl = r1[15:0];
          ph = r1[31:16];
          if (pl > ph) begin
            swap = pl;
            pl   = ph;
            ph   = swap;
          end
        end
      endcase
      cfg_write(CFG_ROT_SPEED, rs);
      cfg_write(CFG_TIME_CONST, tc);
      cfg_write(CFG_PITCH_MIN, pl);
      cfg_write(CFG_PITCH_MAX, ph);

      mode = idle_mode_e'(phase % 4);
      case (mode)
        IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
        IDLE_SENDER:   begin gap_pct = 59; stall_pct = 0;  end
        IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 59; end
        default:       begin gap_pct = 10; stall_pct = 10; end
      endcase

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r0 = $urandom();
        r1 = $urandom();
        r2 = $urandom();
        req.mouse_x   = r0[15:0];
        req.mouse_y   = r0[31:16];
        req.dtime     = r1[15:0];
        req.cur_yaw   = r1[31:16];
        req.cur_pitch = r2[15:0];
        if ($urandom_range(0, 99) < 70) begin
          // Closed loop: the last predicted angles come back as the present ones,
          // so the spring settles and follows instead of being kicked every frame.
          req.cur_yaw   = last_angles.next_yaw;
          req.cur_pitch = last_angles.next_pitch;
          if ($urandom_range(0, 9) != 0) begin
            span = int'($urandom_range(0, 4095)) - 2048;
            req.mouse_x = span[15:0];
            span = int'($urandom_range(0, 4095)) - 2048;
            req.mouse_y = span[15:0];
          end
          pick = $urandom_range(0, 99);
          if (pick < 8) begin
            req.dtime = '0;
          end else if (pick >= 20) begin
            span = int'($urandom_range(300, 3000));
            req.dtime = span[15:0];
          end
        end
        send_request(req, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (END_PAUSE) @(posedge clk_i);
    if (mismatches == 0 && pending_angles.size() == 0)
      $display("pan_tilt_spring_follower_core_test OK");
    else
      $display("pan_tilt_spring_follower_core_test NOT OK");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/ptsf_pkg.sv
rtl/core/ptsf_div.sv
rtl/core/pan_tilt_spring_follower_core.sv
bench/pan_tilt_spring_follower_core_test.sv
